>>> design/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared codes and types of the binary frame collector: sync bytes, op and
// status codes, parser phases and the records passed from front to back.
// ----------------------------------------------------------------------------
package bfc_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	localparam logic [1:0] OP_RECV = 2'd0;
	localparam logic [1:0] OP_DROP = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_LEN_OVF   = 3'd1;
	localparam logic [2:0] ST_BAD_SUM   = 3'd2;
	localparam logic [2:0] ST_BUSY_HELD = 3'd3;
	localparam logic [2:0] ST_DROP_IDLE = 3'd4;

	localparam logic [3:0] PH_SYNC1   = 4'd0;
	localparam logic [3:0] PH_SYNC2   = 4'd1;
	localparam logic [3:0] PH_CLASS   = 4'd2;
	localparam logic [3:0] PH_ID      = 4'd3;
	localparam logic [3:0] PH_LEN_LO  = 4'd4;
	localparam logic [3:0] PH_LEN_HI  = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CHECK_A = 4'd7;
	localparam logic [3:0] PH_CHECK_B = 4'd8;
	localparam logic [3:0] PH_HELD    = 4'd9;

	typedef struct packed {
		logic       msg_ready;
		logic [7:0] msg_class;
		logic [7:0] msg_id;
		logic [7:0] payload_len;
		logic [2:0] status;
	} res_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mem_op_t;

endpackage

>>> design/bfc_ram.sv
// ----------------------------------------------------------------------------
// bfc_ram
// Generic single-write, single-read RAM with registered read data. The read
// register holds its value while no read is issued.
// ----------------------------------------------------------------------------
module bfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/bfc_fifo.sv
// ----------------------------------------------------------------------------
// bfc_fifo
// Four-entry queue between the parser front and the buffer back end.
// ----------------------------------------------------------------------------
module bfc_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int DEPTH = 4;
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

>>> design/bfc_front.sv
// ----------------------------------------------------------------------------
// bfc_front
// Frame parser: takes one beat a cycle while the queue is not full, tracks
// sync, header, payload and check bytes, keeps the Fletcher sums and emits a
// result plus a buffer write or read command into the queue.
// ----------------------------------------------------------------------------
module bfc_front #(
	parameter int FRAME_BUF_BYTES = 256,
	localparam int AW = $clog2(FRAME_BUF_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        read_index,
	input  logic              full,
	output logic              push,
	output bfc_pkg::res_t     res,
	output bfc_pkg::mem_op_t  mop,
	output logic [AW-1:0]     addr,
	output logic [7:0]        wdata
);
	import bfc_pkg::*;

	localparam int MaxLen = FRAME_BUF_BYTES - 8;

	logic [3:0]    phase_q, phase_n;
	logic [AW-1:0] wptr_q, wptr_n;
	logic [AW-1:0] rem_q, rem_n;
	logic [AW-1:0] len_q, len_n;
	logic [7:0]    len_lo_q, len_lo_n;
	logic [7:0]    class_q, class_n;
	logic [7:0]    id_q, id_n;
	logic [7:0]    sum_a_q, sum_a_n;
	logic [7:0]    sum_b_q, sum_b_n;
	logic [7:0]    fcb_q, fcb_n;
	logic [7:0]    sa_add;
	logic [7:0]    sb_add;
	logic [15:0]   len_full;
	logic          too_long;
	logic          restart;
	logic          store;
	logic          accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;
	assign wdata    = rx_byte;

	assign sa_add   = sum_a_q + rx_byte;
	assign sb_add   = sum_b_q + sa_add;
	assign len_full = {rx_byte, len_lo_q};
	assign too_long = 32'(len_full) > MaxLen;

	always_comb begin
		phase_n  = phase_q;
		wptr_n   = wptr_q;
		rem_n    = rem_q;
		len_n    = len_q;
		len_lo_n = len_lo_q;
		class_n  = class_q;
		id_n     = id_q;
		sum_a_n  = sum_a_q;
		sum_b_n  = sum_b_q;
		fcb_n    = fcb_q;
		restart  = 1'b0;
		store    = 1'b0;
		res      = '0;
		mop      = '0;
		addr     = wptr_q;

		case (op)
			OP_RECV: begin
				case (phase_q)
					PH_SYNC1: begin
						if (rx_byte == SYNC_FIRST) begin
							store   = 1'b1;
							phase_n = PH_SYNC2;
						end else begin
							restart = 1'b1;
						end
					end
					PH_SYNC2: begin
						if (rx_byte == SYNC_SECOND) begin
							store   = 1'b1;
							phase_n = PH_CLASS;
						end else begin
							restart = 1'b1;
						end
					end
					PH_CLASS: begin
						store   = 1'b1;
						sum_a_n = sa_add;
						sum_b_n = sb_add;
						class_n = rx_byte;
						phase_n = PH_ID;
					end
					PH_ID: begin
						store   = 1'b1;
						sum_a_n = sa_add;
						sum_b_n = sb_add;
						id_n    = rx_byte;
						phase_n = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						store    = 1'b1;
						sum_a_n  = sa_add;
						sum_b_n  = sb_add;
						len_lo_n = rx_byte;
						phase_n  = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						store   = 1'b1;
						sum_a_n = sa_add;
						sum_b_n = sb_add;
						if (too_long) begin
							res.status = ST_LEN_OVF;
							restart    = 1'b1;
						end else begin
							len_n   = AW'(len_full);
							rem_n   = AW'(len_full);
							phase_n = (len_full != '0) ? PH_PAYLOAD : PH_CHECK_A;
						end
					end
					PH_PAYLOAD: begin
						store   = 1'b1;
						sum_a_n = sa_add;
						sum_b_n = sb_add;
						rem_n   = rem_q - AW'(1);
						if (rem_q == AW'(1)) begin
							phase_n = PH_CHECK_A;
						end
					end
					PH_CHECK_A: begin
						store   = 1'b1;
						fcb_n   = rx_byte;
						phase_n = PH_CHECK_B;
					end
					PH_CHECK_B: begin
						store = 1'b1;
						if (fcb_q == sum_a_q && rx_byte == sum_b_q) begin
							res.msg_ready   = 1'b1;
							res.msg_class   = class_q;
							res.msg_id      = id_q;
							res.payload_len = 8'(len_q);
							phase_n         = PH_HELD;
						end else begin
							res.status = ST_BAD_SUM;
							restart    = 1'b1;
						end
					end
					default: begin
						res.status = ST_BUSY_HELD;
					end
				endcase
			end
			OP_DROP: begin
				if (phase_q == PH_HELD) begin
					restart = 1'b1;
				end else begin
					res.status = ST_DROP_IDLE;
				end
			end
			OP_READ: begin
				addr   = AW'(read_index);
				mop.rd = (32'(read_index) < FRAME_BUF_BYTES);
			end
			default: begin
			end
		endcase

		if (store) begin
			mop.wr = 1'b1;
			wptr_n = wptr_q + AW'(1);
		end
		if (restart) begin
			phase_n = PH_SYNC1;
			wptr_n  = '0;
			rem_n   = '0;
			len_n   = '0;
			sum_a_n = '0;
			sum_b_n = '0;
			fcb_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			wptr_q   <= '0;
			rem_q    <= '0;
			len_q    <= '0;
			len_lo_q <= '0;
			class_q  <= '0;
			id_q     <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			fcb_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			wptr_q   <= wptr_n;
			rem_q    <= rem_n;
			len_q    <= len_n;
			len_lo_q <= len_lo_n;
			class_q  <= class_n;
			id_q     <= id_n;
			sum_a_q  <= sum_a_n;
			sum_b_q  <= sum_b_n;
			fcb_q    <= fcb_n;
		end
	end

	a_hunt_ptr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SYNC1) |-> (wptr_q == '0))
		else $error("write pointer not zero while hunting first sync byte");

	a_sync2_ptr_one: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SYNC2) |-> (wptr_q == AW'(1)))
		else $error("write pointer not one after first sync byte");

	a_drop_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_DROP && phase_q == PH_HELD) |=> (phase_q == PH_SYNC1))
		else $error("drop of held frame did not restart the hunt");

	a_ready_goes_held: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.msg_ready) |=> (phase_q == PH_HELD))
		else $error("completed frame not held");

endmodule

>>> design/bfc_back.sv
// ----------------------------------------------------------------------------
// bfc_back
// Buffer back end: pops queued commands, writes or reads the frame buffer
// and presents the result beat. The RAM read register together with the
// result register forms the output stage.
// ----------------------------------------------------------------------------
module bfc_back #(
	parameter int FRAME_BUF_BYTES = 256,
	localparam int AW = $clog2(FRAME_BUF_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	output logic              pop,
	input  bfc_pkg::res_t     res_h,
	input  bfc_pkg::mem_op_t  mop_h,
	input  logic [AW-1:0]     addr_h,
	input  logic [7:0]        wdata_h,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       out_data,
	output logic [3:0]        out_user
);
	import bfc_pkg::*;

	logic       valid_s1;
	res_t       res_s1;
	logic       rd_s1;
	logic [7:0] ram_q;
	logic [7:0] read_data;

	assign pop = !empty && (!valid_s1 || out_ready);

	bfc_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BUF_BYTES)
	) u_buf (
		.clk   (clk),
		.we    (pop && mop_h.wr),
		.waddr (addr_h),
		.wdata (wdata_h),
		.re    (pop && mop_h.rd),
		.raddr (addr_h),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s1 <= res_h;
			rd_s1  <= mop_h.rd;
		end
	end

	// out-of-range reads and non-read ops return zero
	assign read_data = rd_s1 ? ram_q : 8'd0;

	assign out_valid = valid_s1;
	assign out_data  = {read_data, res_s1.payload_len, res_s1.msg_id, res_s1.msg_class};
	assign out_user  = {res_s1.status, res_s1.msg_ready};

endmodule

>>> design/binary_frame_collector.sv
// ----------------------------------------------------------------------------
// binary_frame_collector
// Collects a byte stream into sync/class/id/length/payload/checksum frames,
// stores every frame byte in a buffer, reports good frames and reads back
// stored bytes.
//
//   channel  | dir | tdata (low bit up)                          | tuser
//   s_axis   | in  | rx_byte, read_index                         | op
//   m_axis   | out | msg_class, msg_id, payload_len, read_data   | msg_ready, status
//
// One beat a cycle in and out while the queue has room and m_axis takes
// results; each input beat yields exactly one result beat. An accepted beat is
// written into a queue entry; the back end pops it into the buffer RAM access,
// with its registered read, and into the result register that drives valid.
// A four-beat queue decouples the parser from the buffer back end, so input
// keeps flowing while m_axis stalls until the queue fills.
// arst_n clears parser state, queue and output valid; buffer content is
// undefined until written.
// ----------------------------------------------------------------------------
module binary_frame_collector #(
	parameter int FRAME_BUF_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], read_index[15:8]
	input  logic [1:0]  s_axis_tuser,   // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // msg_class, msg_id, payload_len, read_data
	output logic [3:0]  m_axis_tuser    // msg_ready[0], status[3:1]
);
	import bfc_pkg::*;

	localparam int AW = $clog2(FRAME_BUF_BYTES);
	localparam int QW = AW + 8 + $bits(mem_op_t) + $bits(res_t);

	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	res_t          res_f;
	mem_op_t       mop_f;
	logic [AW-1:0] addr_f;
	logic [7:0]    wdata_f;
	logic [QW-1:0] q_din;
	logic [QW-1:0] q_dout;
	res_t          res_h;
	mem_op_t       mop_h;
	logic [AW-1:0] addr_h;
	logic [7:0]    wdata_h;

	bfc_front #(
		.FRAME_BUF_BYTES (FRAME_BUF_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.op         (s_axis_tuser),
		.rx_byte    (s_axis_tdata[7:0]),
		.read_index (s_axis_tdata[15:8]),
		.full       (full),
		.push       (push),
		.res        (res_f),
		.mop        (mop_f),
		.addr       (addr_f),
		.wdata      (wdata_f)
	);

	assign q_din = {addr_f, wdata_f, mop_f, res_f};

	bfc_fifo #(
		.WIDTH (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.full   (full),
		.pop    (pop),
		.dout   (q_dout),
		.empty  (empty)
	);

	assign {addr_h, wdata_h, mop_h, res_h} = q_dout;

	bfc_back #(
		.FRAME_BUF_BYTES (FRAME_BUF_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.res_h     (res_h),
		.mop_h     (mop_h),
		.addr_h    (addr_h),
		.wdata_h   (wdata_h),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule
